>>> rtl/huffman_weight_table_decoder_assert.svh
// Assertion macros for the Huffman weight table decoder.
// Used by the top level only; needs clk and arst_n in scope.
`ifndef HUFFMAN_WEIGHT_TABLE_DECODER_ASSERT_SVH
`define HUFFMAN_WEIGHT_TABLE_DECODER_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define HWTD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled during reset.
`define HWTD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> rtl/hwtd_pkg.sv
// Shared types and constants of the Huffman weight table decoder.
// No dependencies; imported by the controller, datapath, top level and bench.
`timescale 1ns / 1ps
`default_nettype none
package hwtd_pkg;
	localparam int WINDOW_W    = 11;
	localparam int WEIGHT_W    = 4;
	localparam int TB_W        = 4;
	localparam int SYM_W       = 8;
	localparam int BC_W        = 4;
	localparam int STAT_W      = 3;
	localparam int TOTAL_W     = 20;
	localparam int RANKS       = 13;
	localparam int RANK_W      = 4;
	localparam int MAX_WEIGHT  = 12;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [STAT_W-1:0] {
		ST_OK, ST_BAD_COUNT, ST_WEIGHT_LARGE, ST_NO_SYMBOLS,
		ST_TOO_LARGE, ST_BAD_SUM, ST_BAD_TERMINAL, ST_NO_TABLE
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_CHK1, S_CHK2, S_PREFIX, S_RD, S_LD, S_WR, S_DONE
	} ctl_state_t;

	typedef struct packed {
		logic idle;
		logic chk1;
		logic chk2;
		logic prefix;
		logic rd;
		logic ld;
		logic wr;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic start;
		logic chk_fail;
		logic prefix_last;
		logic fill_end;
		logic wr_last;
		logic s1_free;
	} sts_t;

	// Number of significant bits of a value (0 for zero).
	function automatic logic [4:0] width_of(input logic [TOTAL_W-1:0] v);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < TOTAL_W; i++) begin
			if (v[i]) begin
				n = 5'(i + 1);
			end
		end
		return n;
	endfunction
endpackage
`default_nettype wire

>>> rtl/hwtd_ctl.sv
// Build sequencer of the Huffman weight table decoder.
// Depends on hwtd_pkg; drives commands to hwtd_dp and reads its status.
`timescale 1ns / 1ps
`default_nettype none
module hwtd_ctl
	import hwtd_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  sts_t sts,
	output cmd_t cmd
);
	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (sts.start) state_d = S_CHK1;
			end
			S_CHK1: begin
				state_d = sts.chk_fail ? S_DONE : S_CHK2;
			end
			S_CHK2: begin
				state_d = sts.chk_fail ? S_DONE : S_PREFIX;
			end
			S_PREFIX: begin
				if (sts.prefix_last) state_d = S_RD;
			end
			S_RD: state_d = S_LD;
			S_LD: state_d = S_WR;
			S_WR: begin
				if (sts.wr_last) state_d = sts.fill_end ? S_DONE : S_RD;
			end
			S_DONE: begin
				if (sts.s1_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:   cmd.idle   = 1'b1;
			S_CHK1:   cmd.chk1   = 1'b1;
			S_CHK2:   cmd.chk2   = 1'b1;
			S_PREFIX: cmd.prefix = 1'b1;
			S_RD:     cmd.rd     = 1'b1;
			S_LD:     cmd.ld     = 1'b1;
			S_WR:     cmd.wr     = 1'b1;
			S_DONE:   cmd.finish = sts.s1_free;
			default:  cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/hwtd_dp.sv
// Datapath of the Huffman weight table decoder: weight store, rank counters,
// decode table memory, result stages. Depends on hwtd_pkg; driven by hwtd_ctl.
`timescale 1ns / 1ps
`default_nettype none
module hwtd_dp
	import hwtd_pkg::*;
#(
	parameter int MAX_TABLE_BITS = 11,
	parameter int MAX_SYMBOLS    = 256
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	input  wire [IN_TDATA_W-1:0]   s_tdata,
	input  wire                    s_tuser,
	input  wire                    s_tlast,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);
	localparam int CW    = $clog2(MAX_SYMBOLS + 1);
	localparam int AW    = $clog2(MAX_SYMBOLS);
	localparam int MT    = MAX_TABLE_BITS + 1;
	localparam int DEPTH = 1 << MAX_TABLE_BITS;

	logic [WEIGHT_W-1:0]       wstore [MAX_SYMBOLS];
	logic [BC_W+SYM_W-1:0]     dtable [DEPTH];

	logic [CW-1:0]             wcount_q;
	logic                      load_err_q;
	logic [CW-1:0]             cnt_q   [RANKS];
	logic [MT-1:0]             start_q [RANKS];
	logic [TOTAL_W-1:0]        total_q;
	logic                      valid_q;
	logic [TB_W-1:0]           index_bits_q;
	status_t                   code_q;
	logic [4:0]                tb_q;
	logic [RANK_W-1:0]         final_w_q;
	logic [RANK_W-1:0]         pw_q;
	logic [MT-1:0]             next_q;
	logic [CW-1:0]             i_q;
	logic [WEIGHT_W-1:0]       rd_w_q;
	logic [RANK_W-1:0]         cur_w_q;
	logic [MAX_TABLE_BITS-1:0] ptr_q;
	logic [MT-1:0]             k_q;
	logic [BC_W+SYM_W-1:0]     entry_q;

	logic                      s1_v_q;
	status_t                   s1_status_q;
	logic [TB_W-1:0]           s1_tb_q;
	logic                      s1_zero_q;

	logic                      m_v_q;
	status_t                   m_status_q;
	logic [TB_W-1:0]           m_tb_q;
	logic [SYM_W-1:0]          m_sym_q;
	logic [BC_W-1:0]           m_bc_q;

	logic                      out_can, s1_free, acc, is_load, dec;
	logic [WEIGHT_W-1:0]       in_w;
	logic [MAX_TABLE_BITS-1:0] win;
	logic                      oor;
	logic                      cnt_en;
	status_t                   chk1_code, chk2_code;
	logic [4:0]                tb_w;
	logic [MT-1:0]             missing;
	logic [RANK_W-1:0]         final_w;
	logic [CW:0]               cnt1_eff;
	logic [MT-1:0]             pre_add;
	logic [RANK_W-1:0]         ld_w;
	logic [MT-1:0]             len;
	logic                      wr_last;
	logic [BC_W-1:0]           bc;
	logic [SYM_W-1:0]          sym;
	logic                      ok;

	assign out_can  = !m_v_q || m_tready;
	assign s1_free  = !s1_v_q || out_can;
	assign s_tready = cmd.idle && s1_free;
	assign acc      = s_tvalid && s_tready;
	assign is_load  = acc && !s_tuser;
	assign dec      = acc && s_tuser;
	assign in_w     = s_tdata[WEIGHT_W-1:0];
	assign win      = s_tdata[WEIGHT_W +: MAX_TABLE_BITS];
	assign oor      = (win >> index_bits_q) != '0;
	assign cnt_en   = is_load && (wcount_q < CW'(MAX_SYMBOLS)) && (in_w != '0)
		&& (in_w <= WEIGHT_W'(MAX_WEIGHT));

	// Weight set checks, in order of priority.
	assign tb_w = width_of(total_q);
	always_comb begin
		if (wcount_q == '0 || wcount_q >= CW'(MAX_SYMBOLS)) chk1_code = ST_BAD_COUNT;
		else if (load_err_q)                                chk1_code = ST_WEIGHT_LARGE;
		else if (total_q == '0)                             chk1_code = ST_NO_SYMBOLS;
		else                                                chk1_code = ST_OK;
	end

	assign missing  = (MT'(1) << tb_q) - MT'(total_q);
	assign final_w  = RANK_W'(width_of(TOTAL_W'(missing)));
	assign cnt1_eff = {1'b0, cnt_q[1]} + (CW+1)'(final_w == RANK_W'(1));
	always_comb begin
		if (tb_q > 5'(MAX_TABLE_BITS))                         chk2_code = ST_TOO_LARGE;
		else if (missing == '0 || (missing & (missing - MT'(1))) != '0)
			chk2_code = ST_BAD_SUM;
		else if (cnt1_eff < (CW+1)'(2) || cnt1_eff[0])          chk2_code = ST_BAD_TERMINAL;
		else                                                   chk2_code = ST_OK;
	end

	assign pre_add = MT'(32'(cnt_q[pw_q]) << (pw_q - RANK_W'(1)));
	assign ld_w    = (i_q == wcount_q) ? final_w_q : RANK_W'(rd_w_q);
	assign len     = MT'(1) << (cur_w_q - RANK_W'(1));
	assign wr_last = (cur_w_q == '0) || (k_q == len - MT'(1));
	assign bc      = BC_W'(tb_q) + BC_W'(1) - BC_W'(cur_w_q);
	assign sym     = SYM_W'(i_q);
	assign ok      = (code_q == ST_OK);

	always_comb begin
		sts             = '0;
		sts.start       = is_load && s_tlast;
		sts.chk_fail    = (cmd.chk1 && chk1_code != ST_OK)
			|| (cmd.chk2 && chk2_code != ST_OK);
		sts.prefix_last = (pw_q == RANK_W'(RANKS - 1));
		sts.fill_end    = (i_q == wcount_q);
		sts.wr_last     = wr_last;
		sts.s1_free     = s1_free;
	end

	// Memories.
	always_ff @(posedge clk) begin
		if (is_load && wcount_q < CW'(MAX_SYMBOLS)) begin
			wstore[wcount_q[AW-1:0]] <= in_w;
		end
		if (cmd.rd) begin
			rd_w_q <= wstore[i_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && cur_w_q != '0) begin
			dtable[ptr_q] <= {bc, sym};
		end
		if (dec) begin
			entry_q <= dtable[win];
		end
	end

	// Load bookkeeping and table state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcount_q     <= '0;
			load_err_q   <= 1'b0;
			total_q      <= '0;
			valid_q      <= 1'b0;
			index_bits_q <= '0;
			for (int r = 0; r < RANKS; r++) cnt_q[r] <= '0;
		end else if (cmd.finish) begin
			wcount_q     <= '0;
			load_err_q   <= 1'b0;
			total_q      <= '0;
			valid_q      <= ok;
			index_bits_q <= ok ? TB_W'(tb_q) : '0;
			for (int r = 0; r < RANKS; r++) cnt_q[r] <= '0;
		end else begin
			if (is_load) begin
				if (wcount_q < CW'(MAX_SYMBOLS)) wcount_q <= wcount_q + CW'(1);
				if (in_w > WEIGHT_W'(MAX_WEIGHT)) load_err_q <= 1'b1;
			end
			if (cnt_en) begin
				cnt_q[RANK_W'(in_w)] <= cnt_q[RANK_W'(in_w)] + CW'(1);
				total_q <= total_q + (TOTAL_W'(1) << (in_w - WEIGHT_W'(1)));
			end
			if (cmd.chk2 && chk2_code == ST_OK) begin
				cnt_q[final_w] <= cnt_q[final_w] + CW'(1);
			end
		end
	end

	// Build working registers.
	always_ff @(posedge clk) begin
		if (cmd.chk1) begin
			code_q <= chk1_code;
			tb_q   <= tb_w;
		end
		if (cmd.chk2) begin
			code_q    <= chk2_code;
			final_w_q <= final_w;
			pw_q      <= RANK_W'(1);
			next_q    <= '0;
			i_q       <= '0;
			start_q[0] <= '0;
		end
		if (cmd.prefix) begin
			start_q[pw_q] <= next_q;
			next_q        <= next_q + pre_add;
			pw_q          <= pw_q + RANK_W'(1);
		end
		if (cmd.ld) begin
			cur_w_q <= ld_w;
			ptr_q   <= MAX_TABLE_BITS'(start_q[ld_w]);
			k_q     <= '0;
		end
		if (cmd.wr) begin
			if (cur_w_q != '0) begin
				ptr_q <= ptr_q + MAX_TABLE_BITS'(1);
				k_q   <= k_q + MT'(1);
			end
			if (wr_last) begin
				if (cur_w_q != '0) start_q[cur_w_q] <= MT'(ptr_q) + MT'(1);
				i_q <= i_q + CW'(1);
			end
		end
	end

	// Result stage one: waits for the decode table read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (dec || cmd.finish) begin
			s1_v_q <= 1'b1;
		end else if (out_can) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dec) begin
			s1_status_q <= valid_q ? ST_OK : ST_NO_TABLE;
			s1_tb_q     <= index_bits_q;
			s1_zero_q   <= !valid_q || oor;
		end else if (cmd.finish) begin
			s1_status_q <= code_q;
			s1_tb_q     <= ok ? TB_W'(tb_q) : '0;
			s1_zero_q   <= 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_v_q <= 1'b0;
		end else if (out_can) begin
			m_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_can && s1_v_q) begin
			m_status_q <= s1_status_q;
			m_tb_q     <= s1_tb_q;
			m_sym_q    <= s1_zero_q ? '0 : entry_q[SYM_W-1:0];
			m_bc_q     <= s1_zero_q ? '0 : entry_q[SYM_W +: BC_W];
		end
	end

	assign m_tvalid = m_v_q;
	assign m_tdata  = {(OUT_TDATA_W - STAT_W - TB_W - SYM_W - BC_W)'(0),
		m_bc_q, m_sym_q, m_tb_q, m_status_q};
endmodule
`default_nettype wire

>>> rtl/huffman_weight_table_decoder.sv
// Huffman weight table decoder top level. Weight loads and decode lookups are
// accepted at one per cycle while the controller is idle and the result stages
// have room; a decode result passes result stage one and the output register.
// A load marked last starts the table build, which writes one table entry per
// cycle in its write state, through the single decode table write port; a build
// that fails its checks ends at the failing check. It then returns one status result.
// Asynchronous active-low reset empties the weight set and drops the table.
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_weight_table_decoder_assert.svh"
module huffman_weight_table_decoder
	import hwtd_pkg::*;
#(
	parameter int MAX_TABLE_BITS = 11,
	parameter int MAX_SYMBOLS    = 256
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	// s_tdata, from the lowest bit: weight[3:0], window[14:4], one pad bit.
	input  wire [IN_TDATA_W-1:0]   s_tdata,
	// s_tuser: action (0 load weight, 1 decode window).
	input  wire                    s_tuser,
	// s_tlast: last weight of the set; starts the build.
	input  wire                    s_tlast,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	// m_tdata, from the lowest bit: status[2:0], table_bits[6:3],
	// symbol[14:7], bit_count[18:15], five pad bits.
	output logic [OUT_TDATA_W-1:0] m_tdata
);
	// The controller sequences the build: checks of the weight set, prefix
	// sum of rank starts, then one pass over the symbols filling the table.
	// A request is taken only while the controller is idle and the result
	// stages have room; results pass a stage and an output register, so a
	// new request can be taken while an earlier result still waits.
	cmd_t cmd;
	sts_t sts;

	hwtd_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	hwtd_dp #(
		.MAX_TABLE_BITS (MAX_TABLE_BITS),
		.MAX_SYMBOLS    (MAX_SYMBOLS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Requests are never taken while a build is running.
	`HWTD_ASSERT_IMP(a_ready_only_idle, s_tready, cmd.idle, "request taken during build")
	// A weight marked last always starts a build.
	`HWTD_ASSERT_NXT(a_last_starts_build, s_tvalid && s_tready && !s_tuser && s_tlast,
		!cmd.idle, "last weight did not start a build")
	// Without a table a lookup discards no bits.
	`HWTD_ASSERT_IMP(a_no_table_no_bits,
		m_tvalid && status_t'(m_tdata[2:0]) == ST_NO_TABLE,
		m_tdata[18:15] == 4'd0, "bits discarded without a table")
endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking bench for the Huffman weight table decoder: it streams weight
// sets and decode windows and checks every result against its own table model.
// Depends on hwtd_pkg and the huffman_weight_table_decoder RTL only.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import hwtd_pkg::*;

	localparam int LIMIT_CYCLES = 1500000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		bit         drain;   // hold the sender until the result stream is empty
		bit         action;
		logic [3:0] weight;
		bit         last;
		logic [10:0] window;
	} request_t;

	typedef struct {
		status_t    st;
		logic [3:0] tb;
		logic [7:0] sym;
		logic [3:0] bc;
	} lookup_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// s_tdata fields from the lowest bit: weight, window, one pad bit.
	logic [IN_TDATA_W-1:0]  s_tdata;
	// s_tuser: action (0 load weight, 1 decode window).
	logic                   s_tuser;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	// m_tdata fields from the lowest bit: status, table_bits, symbol, bit_count.
	logic [OUT_TDATA_W-1:0] m_tdata;

	huffman_weight_table_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	request_t    pending[$];
	lookup_t     expected_results[$];
	int unsigned n_requests;
	int unsigned errors;
	int unsigned cycles;

	// Shadow copy of the decoder state.
	logic [3:0]  weight_mem[256];
	int unsigned weight_cnt;
	bit          weight_bad;
	logic [11:0] lookup_mem[2048];
	int unsigned index_w;
	bit          lookup_ok;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned bits_needed(int unsigned v);
		int unsigned n;
		n = 0;
		while (v != 0) begin
			n++;
			v >>= 1;
		end
		return n;
	endfunction

	// Checks the loaded weights and fills the shadow table; returns the status.
	function status_t build_lookup();
		int unsigned rank[13];
		int unsigned total, tb, missing, final_w, nxt, cur, w, len, bc, start;
		if (weight_cnt == 0 || weight_cnt >= 256) return ST_BAD_COUNT;
		if (weight_bad) return ST_WEIGHT_LARGE;
		foreach (rank[r]) rank[r] = 0;
		total = 0;
		for (int unsigned i = 0; i < weight_cnt; i++) begin
			w = weight_mem[i];
			rank[w]++;
			if (w != 0) total += 1 << (w - 1);
		end
		total &= 32'hFFFFF;
		if (total == 0) return ST_NO_SYMBOLS;
		tb = bits_needed(total);
		if (tb > 11) return ST_TOO_LARGE;
		missing = (1 << tb) - total;
		if (missing == 0 || (missing & (missing - 1)) != 0) return ST_BAD_SUM;
		final_w = bits_needed(missing);
		rank[final_w]++;
		if (rank[1] < 2 || rank[1][0]) return ST_BAD_TERMINAL;
		nxt = 0;
		for (int unsigned r = 1; r <= tb; r++) begin
			cur = nxt;
			nxt += rank[r] << (r - 1);
			rank[r] = cur;
		end
		foreach (lookup_mem[e]) lookup_mem[e] = '0;
		for (int unsigned i = 0; i <= weight_cnt; i++) begin
			w = (i < weight_cnt) ? weight_mem[i] : final_w;
			if (w != 0) begin
				len = 1 << (w - 1);
				bc = tb + 1 - w;
				start = rank[w];
				for (int unsigned k = 0; k < len; k++)
					lookup_mem[(start + k) & 2047] = {bc[3:0], i[7:0]};
				rank[w] = (start + len) & 12'hFFF;
			end
		end
		index_w = tb;
		return ST_OK;
	endfunction

	// Applies one accepted request to the shadow state and queues its result.
	function void predict_request(bit act, logic [3:0] w, bit lst, logic [10:0] win);
		lookup_t res;
		if (!act) begin
			if (weight_cnt < 256) begin
				weight_mem[weight_cnt] = w;
				weight_cnt++;
			end
			if (w > MAX_WEIGHT) weight_bad = 1'b1;
			if (!lst) return;
			res.st = build_lookup();
			lookup_ok = (res.st == ST_OK);
			if (!lookup_ok) index_w = 0;
			weight_cnt = 0;
			weight_bad = 1'b0;
			res.tb = index_w[3:0];
			res.sym = '0;
			res.bc = '0;
		end else if (!lookup_ok) begin
			res.st = ST_NO_TABLE;
			res.tb = index_w[3:0];
			res.sym = '0;
			res.bc = '0;
		end else begin
			res.st = ST_OK;
			res.tb = index_w[3:0];
			res.sym = lookup_mem[win][7:0];
			res.bc = lookup_mem[win][11:8];
		end
		expected_results.push_back(res);
	endfunction

	// Sender: presents queued requests with random gaps, quiet near the end.
	int unsigned send_gap;
	int unsigned drain_cnt;
	always @(posedge clk or negedge arst_n) begin
		bit quiet;
		bit nv;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			s_tlast <= 1'b0;
			send_gap = 0;
			drain_cnt = 0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (s_tvalid) void'(pending.pop_front());
			quiet = pending.size() < 150;
			nv = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending.size() > 0 && pending[0].drain) begin
				// A drain entry holds the sender until every result is back.
				if (expected_results.size() == 0) drain_cnt++;
				if (drain_cnt >= DRAIN_CYCLES) begin
					drain_cnt = 0;
					void'(pending.pop_front());
				end
			end else if (pending.size() > 0) begin
				nv = 1'b1;
				s_tdata <= {1'b0, pending[0].window, pending[0].weight};
				s_tuser <= pending[0].action;
				s_tlast <= pending[0].last;
				if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 18);
			end
			s_tvalid <= nv;
		end
	end

	// Receiver and checker: random stalls, predicts on accept, compares results.
	int unsigned recv_gap;
	always @(posedge clk or negedge arst_n) begin
		lookup_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap = 0;
			weight_cnt = 0;
			weight_bad = 1'b0;
			index_w = 0;
			lookup_ok = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: %h", m_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[2:0] != want.st) begin
						$error("status expected %0d actual %0d", want.st, m_tdata[2:0]);
						errors++;
					end
					if (m_tdata[6:3] != want.tb) begin
						$error("table_bits expected %0d actual %0d", want.tb, m_tdata[6:3]);
						errors++;
					end
					if (m_tdata[14:7] != want.sym) begin
						$error("symbol expected %0d actual %0d", want.sym, m_tdata[14:7]);
						errors++;
					end
					if (m_tdata[18:15] != want.bc) begin
						$error("bit_count expected %0d actual %0d", want.bc, m_tdata[18:15]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_request(s_tuser, s_tdata[3:0], s_tlast, s_tdata[14:4]);
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (pending.size() >= 150 && $urandom_range(0, 9) == 0)
					recv_gap = $urandom_range(1, 18);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic push_load(int unsigned w, bit lst);
		request_t q;
		q = '{drain: 1'b0, action: 1'b0, weight: w[3:0], last: lst, window: 11'($urandom)};
		pending.push_back(q);
		n_requests++;
	endtask

	task automatic push_decode(int unsigned win);
		request_t q;
		q = '{drain: 1'b0, action: 1'b1, weight: 4'($urandom), last: 1'($urandom),
			window: win[10:0]};
		pending.push_back(q);
		n_requests++;
	endtask

	task automatic push_drain();
		request_t q;
		q = '{drain: 1'b1, action: 1'b0, weight: '0, last: 1'b0, window: '0};
		pending.push_back(q);
	endtask

	// Builds a complete code by splitting leaves, drops one leaf as the implied
	// final symbol and sprinkles unused symbols; optionally spoils one weight.
	task automatic push_code_set(int unsigned tb, int unsigned splits, bit spoil);
		int unsigned ws[$];
		int unsigned idx, mn, w, zeros;
		bit has_one;
		ws.push_back(tb + 1);
		for (int s = 0; s < splits && ws.size() < 180; s++) begin
			idx = $urandom_range(0, ws.size() - 1);
			if (ws[idx] > 1) begin
				w = ws[idx] - 1;
				ws[idx] = w;
				ws.insert(idx + 1, w);
			end
		end
		has_one = 1'b0;
		foreach (ws[i]) if (ws[i] == 1) has_one = 1'b1;
		while (!has_one) begin
			mn = 0;
			foreach (ws[i]) if (ws[i] < ws[mn]) mn = i;
			w = ws[mn] - 1;
			ws[mn] = w;
			ws.insert(mn + 1, w);
			if (w == 1) has_one = 1'b1;
		end
		ws.delete($urandom_range(0, ws.size() - 1));
		zeros = $urandom_range(0, 6);
		for (int z = 0; z < zeros; z++) ws.insert($urandom_range(0, ws.size()), 0);
		if (spoil) ws[$urandom_range(0, ws.size() - 1)] = $urandom_range(0, 12);
		foreach (ws[i]) push_load(ws[i], i == ws.size() - 1);
	endtask

	initial begin
		int unsigned tb, r, n;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		n_requests = 0;
		errors = 0;
		cycles = 0;

		// Directed: lookup before any table, then each build error and edge code.
		push_decode(0);
		push_load(0, 1);                         // no symbols
		push_load(13, 0); push_load(1, 1);       // weight too large
		push_load(15, 1);
		push_load(12, 0); push_load(12, 1);      // table too large
		push_load(3, 0); push_load(1, 1);        // bad sum
		push_load(2, 1);                         // bad terminal weights
		push_decode(2047);                       // no table after a failed build
		push_load(1, 1);                         // smallest valid table
		push_decode(0); push_decode(1); push_decode(2047);
		push_code_set(11, 30, 0);                // widest table
		push_decode(0); push_decode(2047); push_decode(1024);
		push_drain();

		// Too many weights: count saturates and the build reports bad count.
		for (int i = 0; i < 258; i++) push_load($urandom_range(0, 12), i == 257);
		for (int i = 0; i < 255; i++) push_load(0, 0);
		push_load(1, 1);                         // exactly the full store

		while (n_requests < 1450) begin
			r = $urandom_range(0, 9);
			if (r <= 6) begin
				tb = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 11);
				push_code_set(tb, $urandom_range(0, 3 * tb), 0);
				n = $urandom_range(3, 25);
				for (int i = 0; i < n; i++)
					push_decode(($urandom_range(0, 7) != 0) ?
						$urandom_range(0, (1 << tb) - 1) : $urandom_range(0, 2047));
			end else if (r == 7) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) push_load($urandom_range(0, 15), i == n - 1);
			end else if (r == 8) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) push_decode($urandom_range(0, 2047));
			end else begin
				push_code_set($urandom_range(1, 6), $urandom_range(0, 10), 1);
				push_decode($urandom_range(0, 63));
			end
			if ($urandom_range(0, 19) == 0) push_drain();
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() > 0 || s_tvalid) @(posedge clk);
		while (expected_results.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
